// ===== src/bcbc_pkg.sv =====
// Package for the battery charge balance controller.
// Holds the shared constants, the mode codes and the configuration struct.
// No dependencies.
package bcbc_pkg;

  localparam int Cells = 4;
  localparam int CellCountWidth = 5;

  localparam logic [15:0] ChargerThresholdReset = 16'd12000;
  localparam logic [15:0] BatteryLowReset = 16'd11000;
  localparam logic [15:0] BatteryFullReset = 16'd16800;
  localparam logic [3:0] BalanceHoldReset = 4'd3;

  localparam int AddrWidth = 4;

  typedef enum logic [1:0] {
    REG_CHARGER_THRESHOLD = 2'd0,
    REG_BATTERY_LOW = 2'd1,
    REG_BATTERY_FULL = 2'd2,
    REG_BALANCE_HOLD = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_SUPERVISOR = 2'd1,
    ERR_VIN_MISMATCH = 2'd2,
    ERR_UNUSED = 2'd3
  } err_code_t;

  typedef enum logic [2:0] {
    MODE_ON = 3'd0,
    MODE_CHARGE = 3'd1,
    MODE_CHARGE_BAL = 3'd2,
    MODE_FULL = 3'd3,
    MODE_FULL_BAL = 3'd4
  } mode_t;

  typedef struct packed {
    logic [15:0] charger_threshold_mv;
    logic [15:0] battery_low_mv;
    logic [15:0] battery_full_mv;
    logic [3:0] balance_hold_ticks;
  } cfg_t;

endpackage

// ===== src/bcbc_cfg.sv =====
// Configuration register file of the battery charge balance controller.
// APB-style write and read access to the four limit registers.
// Depends on bcbc_pkg.
module bcbc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcbc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bcbc_pkg::cfg_t                cfg
);
  import bcbc_pkg::*;

  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charger_threshold_mv <= ChargerThresholdReset;
      cfg.battery_low_mv <= BatteryLowReset;
      cfg.battery_full_mv <= BatteryFullReset;
      cfg.balance_hold_ticks <= BalanceHoldReset;
    end else if (wr_en) begin
      case (index)
        REG_CHARGER_THRESHOLD: cfg.charger_threshold_mv <= pwdata[15:0];
        REG_BATTERY_LOW: cfg.battery_low_mv <= pwdata[15:0];
        REG_BATTERY_FULL: cfg.battery_full_mv <= pwdata[15:0];
        REG_BALANCE_HOLD: cfg.balance_hold_ticks <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_CHARGER_THRESHOLD: prdata = {16'd0, cfg.charger_threshold_mv};
      REG_BATTERY_LOW: prdata = {16'd0, cfg.battery_low_mv};
      REG_BATTERY_FULL: prdata = {16'd0, cfg.battery_full_mv};
      REG_BALANCE_HOLD: prdata = {28'd0, cfg.balance_hold_ticks};
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/battery_charge_balance_controller.sv =====
// Top level of the battery charge balance controller: input register, flag logic,
// five-state charge controller and result register. Depends on bcbc_pkg and bcbc_cfg.
//
// Each tick is registered on transfer, evaluated against the limits and the controller
// state once the result register can take it, and lands in the result register; one tick
// can be taken every cycle while the result side does not stall. The rate is set by the
// single controller state update that each tick makes.
module battery_charge_balance_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    fault_code,
  input  logic [15:0]                   charger_mv,
  input  logic [15:0]                   pack_mv,
  input  logic                          balance_needed,
  input  logic [3:0]                    balance_cell_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          flag_error,
  output logic                          flag_supervisor_fail,
  output logic                          flag_vin_mismatch,
  output logic                          flag_charger_present,
  output logic                          flag_low_battery,
  output logic                          flag_full,
  output logic                          charger_enable,
  output logic                          balancer_enable,
  output logic [3:0]                    balanced_cell,
  output logic [2:0]                    mode_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcbc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bcbc_pkg::*;

  cfg_t cfg;

  bcbc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic        s1_valid;
  err_code_t   s1_err;
  logic [15:0] s1_charger_mv;
  logic [15:0] s1_pack_mv;
  logic        s1_need;
  logic [3:0]  s1_cell;
  logic        advance;

  mode_t       mode;
  logic [3:0]  hold_count;
  logic        charger_level;
  logic        balancer_level;
  logic [3:0]  active_cell;

  mode_t       mode_next;
  logic [3:0]  hold_count_next;
  logic        charger_level_next;
  logic        balancer_level_next;
  logic [3:0]  active_cell_next;

  logic sup_fail;
  logic vin_mis;
  logic present;
  logic low;
  logic full;
  logic request;

  assign advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_err <= err_code_t'(fault_code);
      s1_charger_mv <= charger_mv;
      s1_pack_mv <= pack_mv;
      s1_need <= balance_needed;
      s1_cell <= balance_cell_in;
    end
  end

  assign sup_fail = (s1_err == ERR_SUPERVISOR);
  assign vin_mis = (s1_err == ERR_VIN_MISMATCH);
  assign present = s1_charger_mv > cfg.charger_threshold_mv;
  assign low = s1_pack_mv < cfg.battery_low_mv;
  assign full = !low && (s1_pack_mv > cfg.battery_full_mv);
  assign request = s1_need && ({1'b0, s1_cell} < CellCountWidth'(Cells));

  always_comb begin
    mode_next = mode;
    hold_count_next = hold_count;
    charger_level_next = charger_level;
    balancer_level_next = balancer_level;
    active_cell_next = active_cell;
    case (mode)
      MODE_CHARGE: begin
        if (!present) begin
          charger_level_next = 1'b0;
          mode_next = MODE_ON;
        end else if (full) begin
          charger_level_next = 1'b0;
          mode_next = MODE_FULL;
        end else if (request) begin
          balancer_level_next = 1'b1;
          active_cell_next = s1_cell;
          mode_next = MODE_CHARGE_BAL;
          hold_count_next = cfg.balance_hold_ticks;
        end
      end
      MODE_CHARGE_BAL: begin
        if (full) begin
          charger_level_next = 1'b0;
          mode_next = MODE_FULL;
        end else if (hold_count != 4'd0) begin
          hold_count_next = hold_count - 4'd1;
        end else begin
          balancer_level_next = 1'b0;
          mode_next = MODE_CHARGE;
        end
      end
      MODE_FULL: begin
        if (!present) begin
          mode_next = MODE_ON;
        end else if (!full) begin
          charger_level_next = 1'b1;
          mode_next = MODE_CHARGE;
        end else if (request) begin
          balancer_level_next = 1'b1;
          active_cell_next = s1_cell;
          mode_next = MODE_FULL_BAL;
          hold_count_next = cfg.balance_hold_ticks;
        end
      end
      MODE_FULL_BAL: begin
        if (!full) begin
          charger_level_next = 1'b1;
          mode_next = MODE_CHARGE_BAL;
        end else if (hold_count != 4'd0) begin
          hold_count_next = hold_count - 4'd1;
        end else begin
          balancer_level_next = 1'b0;
          mode_next = MODE_FULL;
        end
      end
      default: begin
        if (present) begin
          charger_level_next = 1'b1;
          mode_next = MODE_CHARGE;
        end else begin
          mode_next = MODE_ON;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ON;
      hold_count <= 4'd0;
      charger_level <= 1'b0;
      balancer_level <= 1'b0;
      active_cell <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        mode <= mode_next;
        hold_count <= hold_count_next;
        charger_level <= charger_level_next;
        balancer_level <= balancer_level_next;
        active_cell <= active_cell_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      flag_error <= sup_fail || vin_mis;
      flag_supervisor_fail <= sup_fail;
      flag_vin_mismatch <= vin_mis;
      flag_charger_present <= present;
      flag_low_battery <= low;
      flag_full <= full;
      charger_enable <= charger_level_next;
      balancer_enable <= balancer_level_next;
      balanced_cell <= active_cell_next;
      mode_out <= mode_next;
    end
  end

  // The charger runs exactly in the two charging modes.
  assert property (@(posedge clk) disable iff (rst)
    charger_level == ((mode == MODE_CHARGE) || (mode == MODE_CHARGE_BAL)))
    else $error("charger level does not match the charge mode");

  // Both balancing modes keep the balancer switched on.
  assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_CHARGE_BAL) || (mode == MODE_FULL_BAL)) |-> balancer_level)
    else $error("balancing mode with the balancer off");

  // A full pack is never reported together with a low pack.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(flag_full && flag_low_battery))
    else $error("full and low flags raised together");

  // With the result register empty, the input side always takes a transfer.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule
